// File: rtl/core/plti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants for the piecewise linear table interpolator:
// command and result beats, function codes and status codes.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int CFG_W       = 9;
    localparam int FRAC_W      = 16;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP   = 2'd0,
        ST_CLAMP_LO = 2'd1,
        ST_CLAMP_HI = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic               func;
        logic [7:0]         entry_index;
        logic [31:0]        time_point;
        logic signed [31:0] entry_value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] result_value;
        t_status            status;
    } t_result;

endpackage

// File: rtl/core/piecewise_linear_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator
// Breakpoint table with fixed point linear interpolation, run by a small
// microcoded sequencer over one table memory, a search unit, a radix-2
// divider and one multiplier.
// ----------------------------------------------------------------------------
// Load: no result, and busy stays low; the next beat is taken in the following cycle.
// Query: an empty table, a time clamped low and a time clamped high end without a search;
//   otherwise k <= floor(log2(n)) + 1 search probes find the pair, a flat pair returns its
//   lower value and any other pair is interpolated with 17 divide steps.
// busy drops in the cycle the result is shown, so the next beat may enter.
// Synchronous active low reset clears the sequencer, strobe and entry count only.
module piecewise_linear_table_interpolator (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  plti_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_wdata,
    output logic              o_done,
    output plti_pkg::t_result o_result
);
    import plti_pkg::*;

    localparam int Q_W    = FRAC_W + 1;
    localparam int DCNT_W = $clog2(Q_W);
    localparam int PROD_W = Q_W + 1 + 33;

    typedef logic [4:0] t_step;

    typedef enum logic [2:0] {
        A_ZERO, A_LAST, A_MID, A_LO, A_HI
    } t_asel;

    typedef enum logic [3:0] {
        OP_NOP, OP_INIT, OP_SAVE0, OP_SAVE1, OP_SEARCH, OP_HIT,
        OP_DIV_PREP, OP_DIV_CLAMP, OP_DIV_STEP, OP_MUL,
        OP_OUT_ZERO, OP_OUT_V0, OP_OUT_V1, OP_OUT_SUM
    } t_op;

    typedef enum logic [3:0] {
        C_NEXT, C_ALWAYS, C_WAIT, C_EMPTY, C_T_LE, C_T_GE,
        C_CNT_ZERO, C_FLAT, C_DIV_MORE
    } t_cond;

    typedef struct packed {
        t_asel   asel;
        t_op     op;
        t_cond   cond;
        t_step   target;
        t_status status;
    } t_uword;

    localparam t_step S_IDLE     = 5'd0;
    localparam t_step S_CHK      = 5'd1;
    localparam t_step S_LOW      = 5'd2;
    localparam t_step S_HIGH     = 5'd3;
    localparam t_step S_PROBE    = 5'd4;
    localparam t_step S_CMP      = 5'd5;
    localparam t_step S_FETCH    = 5'd6;
    localparam t_step S_LD0      = 5'd7;
    localparam t_step S_LD1      = 5'd8;
    localparam t_step S_PREP     = 5'd9;
    localparam t_step S_CLAMP    = 5'd10;
    localparam t_step S_DIV      = 5'd11;
    localparam t_step S_MUL      = 5'd12;
    localparam t_step S_SUM      = 5'd13;
    localparam t_step S_EMPTY    = 5'd14;
    localparam t_step S_OUT_LO   = 5'd15;
    localparam t_step S_OUT_HI   = 5'd16;
    localparam t_step S_OUT_FLAT = 5'd17;

    // Control store: one word per step; a taken condition jumps to target.
    function automatic t_uword f_ucode(input t_step pc);
        t_uword uw;
        unique case (pc)
            S_IDLE:     uw = '{A_ZERO, OP_NOP,       C_WAIT,     S_IDLE,     ST_INTERP};
            S_CHK:      uw = '{A_ZERO, OP_INIT,      C_EMPTY,    S_EMPTY,    ST_INTERP};
            S_LOW:      uw = '{A_LAST, OP_SAVE0,     C_T_LE,     S_OUT_LO,   ST_INTERP};
            S_HIGH:     uw = '{A_ZERO, OP_SAVE1,     C_T_GE,     S_OUT_HI,   ST_INTERP};
            S_PROBE:    uw = '{A_MID,  OP_NOP,       C_CNT_ZERO, S_FETCH,    ST_INTERP};
            S_CMP:      uw = '{A_MID,  OP_SEARCH,    C_ALWAYS,   S_PROBE,    ST_INTERP};
            S_FETCH:    uw = '{A_LO,   OP_HIT,       C_NEXT,     S_IDLE,     ST_INTERP};
            S_LD0:      uw = '{A_HI,   OP_SAVE0,     C_NEXT,     S_IDLE,     ST_INTERP};
            S_LD1:      uw = '{A_ZERO, OP_SAVE1,     C_NEXT,     S_IDLE,     ST_INTERP};
            S_PREP:     uw = '{A_ZERO, OP_DIV_PREP,  C_FLAT,     S_OUT_FLAT, ST_INTERP};
            S_CLAMP:    uw = '{A_ZERO, OP_DIV_CLAMP, C_NEXT,     S_IDLE,     ST_INTERP};
            S_DIV:      uw = '{A_ZERO, OP_DIV_STEP,  C_DIV_MORE, S_DIV,      ST_INTERP};
            S_MUL:      uw = '{A_ZERO, OP_MUL,       C_NEXT,     S_IDLE,     ST_INTERP};
            S_SUM:      uw = '{A_ZERO, OP_OUT_SUM,   C_ALWAYS,   S_IDLE,     ST_INTERP};
            S_EMPTY:    uw = '{A_ZERO, OP_OUT_ZERO,  C_ALWAYS,   S_IDLE,     ST_EMPTY};
            S_OUT_LO:   uw = '{A_ZERO, OP_OUT_V0,    C_ALWAYS,   S_IDLE,     ST_CLAMP_LO};
            S_OUT_HI:   uw = '{A_ZERO, OP_OUT_V1,    C_ALWAYS,   S_IDLE,     ST_CLAMP_HI};
            S_OUT_FLAT: uw = '{A_ZERO, OP_OUT_V0,    C_ALWAYS,   S_IDLE,     ST_INTERP};
            default:    uw = '{A_ZERO, OP_NOP,       C_ALWAYS,   S_IDLE,     ST_INTERP};
        endcase
        return uw;
    endfunction

    // Table memory: {time, value} per row.
    logic [63:0]              r_mem [TABLE_DEPTH];
    logic [31:0]              r_rd_time;
    logic signed [31:0]       r_rd_value;

    logic [CFG_W-1:0]         r_entry_count;
    t_step                    r_pc;
    t_step                    n_pc;
    logic                     r_done;
    t_result                  r_result;

    logic [31:0]              r_t;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_first;
    logic [CNT_W-1:0]         r_count;
    logic [31:0]              r_t0;
    logic [31:0]              r_t1;
    logic signed [31:0]       r_v0;
    logic signed [31:0]       r_v1;
    logic [31:0]              r_span;
    logic [32:0]              r_rem;
    logic signed [32:0]       r_dv;
    logic [Q_W-1:0]           r_q;
    logic [DCNT_W-1:0]        r_dcnt;
    logic signed [PROD_W-1:0] r_prod;

    t_uword                   w_uw;
    logic                     w_jump;
    logic                     w_load;
    logic                     w_query;
    logic [CNT_W-1:0]         w_n;
    logic [CNT_W-1:0]         w_half;
    logic [CNT_W-1:0]         w_mid;
    logic [CNT_W-1:0]         w_hit;
    logic [ADDR_W-1:0]        w_addr;
    logic [32:0]              w_diff;
    logic                     w_qbit;

    assign busy     = (r_pc != S_IDLE);
    assign w_load   = start && !busy && (i_cmd.func == FUNC_LOAD);
    assign w_query  = start && !busy && (i_cmd.func == FUNC_QUERY);
    assign w_uw     = f_ucode(r_pc);
    assign o_done   = r_done;
    assign o_result = r_result;

    always_comb begin
        if (32'(r_entry_count) > TABLE_DEPTH) begin
            w_n = CNT_W'(TABLE_DEPTH);
        end else begin
            w_n = CNT_W'(r_entry_count);
        end
    end

    assign w_half = r_count >> 1;
    assign w_mid  = r_first + w_half;

    // Bracket the upper breakpoint within 1..n-1.
    always_comb begin
        priority if (r_first == '0) begin
            w_hit = CNT_W'(1);
        end else if (r_first > r_n - CNT_W'(1)) begin
            w_hit = r_n - CNT_W'(1);
        end else begin
            w_hit = r_first;
        end
    end

    always_comb begin
        unique case (w_uw.asel)
            A_ZERO:  w_addr = '0;
            A_LAST:  w_addr = ADDR_W'(r_n - CNT_W'(1));
            A_MID:   w_addr = ADDR_W'(w_mid);
            A_LO:    w_addr = ADDR_W'(w_hit - CNT_W'(1));
            A_HI:    w_addr = ADDR_W'(r_first);
            default: w_addr = '0;
        endcase
    end

    assign w_diff = r_rem - {1'b0, r_span};
    assign w_qbit = (r_rem >= {1'b0, r_span});

    always_comb begin
        unique case (w_uw.cond)
            C_NEXT:     w_jump = 1'b0;
            C_ALWAYS:   w_jump = 1'b1;
            C_WAIT:     w_jump = !w_query;
            C_EMPTY:    w_jump = (r_n == '0);
            C_T_LE:     w_jump = (r_t <= r_rd_time);
            C_T_GE:     w_jump = (r_t >= r_rd_time);
            C_CNT_ZERO: w_jump = (r_count == '0);
            C_FLAT:     w_jump = (r_t1 <= r_t0);
            C_DIV_MORE: w_jump = (r_dcnt != '0);
            default:    w_jump = 1'b1;
        endcase
        n_pc = w_jump ? w_uw.target : r_pc + 5'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= S_IDLE;
            r_done        <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_pc   <= n_pc;
            r_done <= (w_uw.op == OP_OUT_ZERO) || (w_uw.op == OP_OUT_V0) ||
                      (w_uw.op == OP_OUT_V1) || (w_uw.op == OP_OUT_SUM);
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (32'(i_cmd.entry_index) < TABLE_DEPTH)) begin
            r_mem[ADDR_W'(i_cmd.entry_index)] <= {i_cmd.time_point, i_cmd.entry_value};
        end
        {r_rd_time, r_rd_value} <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_t <= i_cmd.time_point;
            r_n <= w_n;
        end
        r_result.status <= w_uw.status;
        unique case (w_uw.op)
            OP_INIT: begin
                r_first <= '0;
                r_count <= r_n;
            end
            OP_SAVE0: begin
                r_t0 <= r_rd_time;
                r_v0 <= r_rd_value;
            end
            OP_SAVE1: begin
                r_t1 <= r_rd_time;
                r_v1 <= r_rd_value;
            end
            OP_SEARCH: begin
                if (r_rd_time < r_t) begin
                    r_first <= w_mid + CNT_W'(1);
                    r_count <= r_count - w_half - CNT_W'(1);
                end else begin
                    r_count <= w_half;
                end
            end
            OP_HIT: begin
                r_first <= w_hit;
            end
            OP_DIV_PREP: begin
                r_span <= r_t1 - r_t0;
                r_rem  <= (r_t <= r_t0) ? 33'd0 : {1'b0, r_t - r_t0};
                r_dv   <= {r_v1[31], r_v1} - {r_v0[31], r_v0};
            end
            OP_DIV_CLAMP: begin
                if (r_rem > {1'b0, r_span}) begin
                    r_rem <= {1'b0, r_span};
                end
                r_q    <= '0;
                r_dcnt <= DCNT_W'(Q_W - 1);
            end
            OP_DIV_STEP: begin
                // Remainder stays below the span, so the shift never overflows.
                r_rem  <= w_qbit ? {w_diff[31:0], 1'b0} : {r_rem[31:0], 1'b0};
                r_q    <= {r_q[Q_W-2:0], w_qbit};
                r_dcnt <= r_dcnt - DCNT_W'(1);
            end
            OP_MUL: begin
                r_prod <= $signed({1'b0, r_q}) * r_dv;
            end
            OP_OUT_ZERO: r_result.result_value <= '0;
            OP_OUT_V0:   r_result.result_value <= r_v0;
            OP_OUT_V1:   r_result.result_value <= r_v1;
            OP_OUT_SUM:  r_result.result_value <= r_v0 + r_prod[FRAC_W+31:FRAC_W];
            default: begin
            end
        endcase
    end

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_QUERY) |=> busy)
        else $error("query accepted but sequencer did not start");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_LOAD) |=> (!busy && !o_done))
        else $error("load beat produced activity");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_EMPTY) |-> (r_n == '0))
        else $error("empty status with entries in use");
`endif

endmodule

// File: tb/sv/piecewise_linear_table_interpolator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_checker
// Watches the command and result channels of the interpolator. It keeps its
// own breakpoint table and entry count, and works out the value and status of
// every accepted query. It then compares each result beat with the oldest
// outstanding lookup.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interpolator_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  plti_pkg::t_cmd    i_cmd,
    input  logic              i_cfg_we,
    input  logic [8:0]        i_cfg_wdata,
    input  logic              i_done,
    input  plti_pkg::t_result i_result,
    output int                o_fail_count,
    output int                o_pending
);
    import plti_pkg::*;

    logic [31:0]        bp_time  [TABLE_DEPTH];
    logic signed [31:0] bp_value [TABLE_DEPTH];
    logic [8:0]         entry_count;
    t_result            lookups_due[$];
    t_result            due;
    int                 mismatches = 0;
    int                 outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;

    // Blend slots lo and lo + 1 at time t with a Q1.16 weight.
    function automatic logic signed [31:0] blend(input int lo, input logic [31:0] t);
        longint t0, t1, v0, v1, tq, span, off, w, prod;
        t0 = longint'(bp_time[lo]);
        t1 = longint'(bp_time[lo + 1]);
        v0 = longint'(bp_value[lo]);
        v1 = longint'(bp_value[lo + 1]);
        tq = longint'(t);
        if (t1 <= t0)
            return 32'(v0);
        span = t1 - t0;
        off  = (tq <= t0) ? 64'sd0 : tq - t0;
        if (off > span)
            off = span;
        w    = (off << 16) / span;
        prod = w * (v1 - v0);
        // arithmetic shift floors toward minus infinity
        return 32'(v0 + (prod >>> FRAC_W));
    endfunction

    function automatic t_result lookup_at(input logic [31:0] t);
        t_result r;
        int      n, first, cnt, half, hit;
        n = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        if (n == 0) begin
            r.result_value = '0;
            r.status       = ST_EMPTY;
        end else if (t <= bp_time[0]) begin
            r.result_value = bp_value[0];
            r.status       = ST_CLAMP_LO;
        end else if (t >= bp_time[n - 1]) begin
            r.result_value = bp_value[n - 1];
            r.status       = ST_CLAMP_HI;
        end else begin
            // lower bound: first slot whose time is not below t
            first = 0;
            cnt   = n;
            while (cnt > 0) begin
                half = cnt / 2;
                if (bp_time[first + half] < t) begin
                    first = first + half + 1;
                    cnt   = cnt - half - 1;
                end else begin
                    cnt = half;
                end
            end
            hit = first;
            if (hit < 1)
                hit = 1;
            if (hit > n - 1)
                hit = n - 1;
            r.result_value = blend(hit - 1, t);
            r.status       = ST_INTERP;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_count = '0;
            lookups_due.delete();
        end else begin
            // retire the oldest lookup before taking a new beat in the same cycle
            if (i_done === 1'b1) begin
                if (lookups_due.size() == 0) begin
                    $error("result beat with no lookup outstanding: value %0d status %0d",
                           i_result.result_value, i_result.status);
                    mismatches++;
                end else begin
                    due = lookups_due.pop_front();
                    if (i_result.result_value !== due.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               due.result_value, i_result.result_value);
                        mismatches++;
                    end
                    if (i_result.status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_result.status);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we === 1'b1)
                entry_count = i_cfg_wdata;
            if (i_start === 1'b1 && i_busy === 1'b0) begin
                if (i_cmd.func == FUNC_LOAD) begin
                    bp_time[i_cmd.entry_index]  = i_cmd.time_point;
                    bp_value[i_cmd.entry_index] = i_cmd.entry_value;
                end else begin
                    lookups_due.insert(lookups_due.size(), lookup_at(i_cmd.time_point));
                end
            end
        end
        outstanding = lookups_due.size();
    end

endmodule

// File: tb/sv/tb_piecewise_linear_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_piecewise_linear_table_interpolator
// Loads breakpoint tables and sends queries to the interpolator, first a
// directed set of corner cases, then random tables and lookups over many
// entry counts. Random gaps, sometimes none, are put between beats. The checker
// predicts and compares. This module gives the verdict.
// ----------------------------------------------------------------------------
module tb_piecewise_linear_table_interpolator;
    import plti_pkg::*;

    localparam int ITEM_TARGET  = 1250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int LOAD_SETTLE  = 4;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    t_cmd        i_cmd       = '0;
    logic        i_cfg_we    = 1'b0;
    logic [8:0]  i_cfg_wdata = '0;
    logic        busy;
    logic        o_done;
    t_result     o_result;

    int          fail_count;
    int          pending;
    int          beats_sent   = 0;
    int          stall_cycles = 0;
    int          active_n     = 0;
    bit          no_gaps      = 1'b0;
    logic [31:0] slot_time [TABLE_DEPTH];

    always #5 i_clk = ~i_clk;

    piecewise_linear_table_interpolator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    piecewise_linear_table_interpolator_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Stop when neither channel has moved for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_piecewise_linear_table_interpolator: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_beat(input logic f, input logic [7:0] idx,
                             input logic [31:0] t, input logic [31:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start             = 1'b1;
        i_cmd.func        = f;
        i_cmd.entry_index = idx;
        i_cmd.time_point  = t;
        i_cmd.entry_value = v;
        do @(posedge i_clk); while (busy !== 1'b0);
        beats_sent++;
    endtask

    task automatic load_slot(input logic [7:0] idx, input logic [31:0] t,
                             input logic [31:0] v);
        send_beat(FUNC_LOAD, idx, t, v);
        slot_time[idx] = t;
    endtask

    task automatic ask_at(input logic [31:0] t);
        send_beat(FUNC_QUERY, 8'($urandom), t, $urandom);
    endtask

    // Drain all lookups and let any load settle before touching the count.
    task automatic set_count(input int val);
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (LOAD_SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = 9'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        active_n = (val > TABLE_DEPTH) ? TABLE_DEPTH : val;
    endtask

    // Load slots 0..n-1, mostly with strictly rising times.
    task automatic fill_table(input int n);
        logic [31:0] times [TABLE_DEPTH];
        logic [31:0] vals  [TABLE_DEPTH];
        longint      step_max, room, acc;
        int          shape, vshape, i, k;
        bit          down;
        shape  = $urandom_range(0, 9);
        vshape = $urandom_range(0, 3);
        down   = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
            0:       step_max = 1;
            1:       step_max = 255;
            2:       step_max = 65535;
            default: step_max = 64'h0000_0000_FFFF_FFFF / n;
        endcase
        room = 64'h0000_0000_FFFF_FFFF - step_max * n;
        acc  = longint'({$urandom, $urandom} % 64'(room + 1));
        if ($urandom_range(0, 7) == 0)
            acc = 0;
        for (i = 0; i < n; i++) begin
            if (shape == 0) begin
                // broken ordering: repeats and arbitrary times
                times[i] = (i > 0 && $urandom_range(0, 1)) ? times[i - 1] : $urandom;
            end else begin
                times[i] = 32'(acc);
                acc      = acc + $urandom_range(1, 32'(step_max));
            end
            case (vshape)
                0: vals[i] = $urandom;
                1: vals[i] = 32'(($urandom_range(0, 2000) - 1000) * 256);
                2: vals[i] = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: vals[i] = 32'($urandom_range(0, 65535)) - 32'd32768;
            endcase
        end
        for (k = 0; k < n; k++) begin
            i = down ? n - 1 - k : k;
            load_slot(8'(i), times[i], vals[i]);
        end
    endtask

    function automatic logic [31:0] pick_time();
        int     i;
        longint a, b, lo, hi;
        if (active_n == 0)
            return $urandom;
        case ($urandom_range(0, 9))
            0, 1: return slot_time[$urandom_range(0, active_n - 1)];
            2, 3, 4: begin
                if (active_n < 2)
                    return $urandom;
                i  = $urandom_range(0, active_n - 2);
                a  = longint'(slot_time[i]);
                b  = longint'(slot_time[i + 1]);
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
                return 32'(lo + longint'($urandom) % (hi - lo + 1));
            end
            5: return $urandom_range(0, 1) ? 32'h0 : slot_time[0] - $urandom_range(0, 3);
            6: return $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                           : slot_time[active_n - 1] + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int pick, n;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table, both ends of the time range
        ask_at(32'h0);
        send_beat(FUNC_QUERY, 8'hFF, 32'hFFFF_FFFF, 32'h8000_0000);

        // full-scale swing between the first two breakpoints
        load_slot(8'd0, 32'h0000_0000, 32'h8000_0000);
        load_slot(8'd1, 32'h0001_0000, 32'h7FFF_FFFF);
        load_slot(8'd2, 32'hFFFF_FFFF, 32'h0000_0000);
        load_slot(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_count(3);
        ask_at(32'h0000_0000);
        ask_at(32'h0000_8000);
        ask_at(32'h0000_FFFF);
        ask_at(32'h0001_0000);
        ask_at(32'h8000_0000);
        ask_at(32'hFFFF_FFFE);
        ask_at(32'hFFFF_FFFF);

        // single breakpoint: every time clamps
        set_count(1);
        ask_at(32'h0000_0000);
        ask_at(32'h0000_1234);

        // repeated time at the head of the table
        load_slot(8'd1, 32'h0000_0000, 32'h1234_5678);
        set_count(3);
        ask_at(32'h0000_0001);
        ask_at(32'h7FFF_FFFF);

        // every slot, then counts at and above the depth, then a count of zero
        fill_table(TABLE_DEPTH);
        set_count(TABLE_DEPTH);
        repeat (30) ask_at(pick_time());
        set_count(511);
        repeat (8) ask_at(pick_time());
        set_count(0);
        repeat (4) ask_at(pick_time());

        while (beats_sent < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            pick    = $urandom_range(0, 19);
            if (pick == 0) begin
                set_count(0);
            end else if (pick == 1) begin
                set_count($urandom_range(TABLE_DEPTH, 511));
            end else begin
                n = (pick < 16) ? $urandom_range(1, 8) : $urandom_range(9, 48);
                fill_table(n);
                set_count(n);
            end
            repeat ($urandom_range(6, 24)) begin
                if ($urandom_range(0, 9) == 0)
                    load_slot(8'($urandom), $urandom, $urandom);
                else
                    ask_at(pick_time());
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_piecewise_linear_table_interpolator: PASS");
        else
            $display("tb_piecewise_linear_table_interpolator: FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/plti_pkg.sv
rtl/core/piecewise_linear_table_interpolator.sv
tb/sv/piecewise_linear_table_interpolator_checker.sv
tb/sv/tb_piecewise_linear_table_interpolator.sv
